// ----- src/csfw_pkg.sv -----
`timescale 1ns / 1ps

package csfw_pkg;

   // command codes
   localparam logic [1:0] CMD_WAIT   = 2'd0;
   localparam logic [1:0] CMD_SIGNAL = 2'd1;
   localparam logic [1:0] CMD_CLOSE  = 2'd2;
   localparam logic [1:0] CMD_RSVD   = 2'd3;

   // result status codes
   localparam logic [2:0] ST_GRANTED   = 3'd0;
   localparam logic [2:0] ST_QUEUED    = 3'd1;
   localparam logic [2:0] ST_REFUSED   = 3'd2;
   localparam logic [2:0] ST_RELEASED  = 3'd3;
   localparam logic [2:0] ST_CLOSE_REL = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;
   localparam logic [2:0] ST_FULL      = 3'd6;

   // sequencer to waiter queue controls
   typedef struct packed {
      logic clear;  // empty the queue
      logic push;   // append at tail
      logic pop;    // drop the head
      logic upd;    // rewrite the head's need
   } csfw_qctl_type;

endpackage

// ----- src/csfw_queue.sv -----
`timescale 1ns / 1ps

module csfw_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  csfw_pkg::csfw_qctl_type    ctl,
   input  logic [7:0]                 push_id,
   input  logic [15:0]                push_need,
   input  logic [15:0]                upd_need,
   output logic [7:0]                 rd_id,
   output logic [15:0]                rd_need,
   output logic                       full,
   output logic                       empty
);
   import csfw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_MAX   = OCC_W'(QUEUE_DEPTH);

   logic [7:0]       id_mem   [QUEUE_DEPTH];
   logic [15:0]      need_mem [QUEUE_DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [7:0]       rd_id_ff;
   logic [15:0]      rd_need_ff;
   logic [PTR_W-1:0] need_waddr;
   logic [15:0]      need_wdata;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // pointer and fill count update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      if (ctl.clear) begin
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
      end else if (ctl.push) begin
         tail_in = next_slot(tail_ff);
         occ_in  = occ_ff + 1'b1;
      end else if (ctl.pop) begin
         head_in = next_slot(head_ff);
         occ_in  = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   // single write port: push at tail, need rewrite at head
   assign need_waddr = ctl.push ? tail_ff : head_ff;
   assign need_wdata = ctl.push ? push_need : upd_need;

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.clear) begin
         id_mem[tail_ff] <= push_id;
      end
      if ((ctl.push || ctl.upd) && !ctl.clear) begin
         need_mem[need_waddr] <= need_wdata;
      end
   end

   // registered read of the head entry
   always_ff @(posedge clock) begin
      rd_id_ff   <= id_mem[head_ff];
      rd_need_ff <= need_mem[head_ff];
   end

   assign rd_id   = rd_id_ff;
   assign rd_need = rd_need_ff;
   assign full    = (occ_ff == OCC_MAX);
   assign empty   = (occ_ff == '0);

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (ctl.push && !ctl.clear) |-> !full)
      else $error("push into full waiter queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (ctl.pop && !ctl.clear) |-> !empty)
      else $error("pop from empty waiter queue");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");
`endif

endmodule

// ----- src/counting_semaphore_fifo_waiters.sv -----
`timescale 1ns / 1ps
// Wait: S_WCMP compares, then the result word; a queued thread also passes S_WNEED.
// Signal/close: per waiter released from the queue head, head read, compare on the
// shared subtractor, result word; the done word then follows S_SHEAD on an empty close,
// S_SHEAD, S_SADD on a signal into an empty queue, S_SHEAD, S_SCMP, S_SREM otherwise.
// One command in flight; next accept in the cycle after its last word, plus stalls.
// Reset (synchronous, active high): count and initial_count zero, queue empty, open.
module counting_semaphore_fifo_waiters #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_thread_id,
   input  logic [15:0] req_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_thread_id_out,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_initial_count
);
   import csfw_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WCMP  = 3'd1;
   localparam logic [2:0] S_WNEED = 3'd2;
   localparam logic [2:0] S_SHEAD = 3'd3;
   localparam logic [2:0] S_SCMP  = 3'd4;
   localparam logic [2:0] S_SREM  = 3'd5;
   localparam logic [2:0] S_SADD  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    ret_ff, ret_in;
   logic          closed_ff, closed_in;
   logic          close_ff, close_in;
   logic [15:0]   init_ff, init_in;
   logic [31:0]   avail_ff, avail_in;
   logic [7:0]    tid_ff, tid_in;
   logic [15:0]   n_ff, n_in;
   logic [7:0]    rsp_tid_ff, rsp_tid_in;
   logic [2:0]    rsp_st_ff, rsp_st_in;
   logic          rsp_last_ff, rsp_last_in;

   // result word staging
   logic          emit;
   logic [7:0]    emit_tid;
   logic [2:0]    emit_st;
   logic          emit_last;
   logic [2:0]    emit_ret;

   // shared add/subtract unit
   logic [31:0]   alu_a, alu_b;
   logic          alu_sub;
   logic [32:0]   alu_res;

   csfw_qctl_type qctl;
   logic [7:0]    q_rd_id;
   logic [15:0]   q_rd_need;
   logic          q_full, q_empty;

   csfw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (qctl),
      .push_id   (tid_ff),
      .push_need (alu_res[15:0]),
      .upd_need  (alu_res[15:0]),
      .rd_id     (q_rd_id),
      .rd_need   (q_rd_need),
      .full      (q_full),
      .empty     (q_empty)
   );

   // operand select; res[32] is carry (no borrow on subtract)
   always_comb begin
      alu_sub = 1'b1;
      case (state_ff)
         S_WNEED: begin
            alu_a = {16'b0, n_ff};
            alu_b = avail_ff;
         end
         S_SCMP: begin
            alu_a = {16'b0, n_ff};
            alu_b = {16'b0, q_rd_need};
         end
         S_SREM: begin
            alu_a = {16'b0, q_rd_need};
            alu_b = {16'b0, n_ff};
         end
         S_SADD: begin
            alu_a   = avail_ff;
            alu_b   = {16'b0, n_ff};
            alu_sub = 1'b0;
         end
         default: begin
            alu_a = avail_ff;
            alu_b = {16'b0, n_ff};
         end
      endcase
   end

   assign alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {32{alu_sub}}} + {32'b0, alu_sub};

   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      closed_in = closed_ff;
      close_in  = close_ff;
      init_in   = init_ff;
      avail_in  = avail_ff;
      tid_in    = tid_ff;
      n_in      = n_ff;
      qctl      = '0;
      emit      = 1'b0;
      emit_tid  = 8'd0;
      emit_st   = ST_DONE;
      emit_last = 1'b1;
      emit_ret  = S_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               init_in    = csr_initial_count;
               avail_in   = {16'b0, csr_initial_count};
               closed_in  = 1'b0;
               qctl.clear = 1'b1;
            end else if (req_valid) begin
               tid_in   = req_thread_id;
               n_in     = req_count;
               close_in = (req_cmd == CMD_CLOSE);
               if (req_cmd == CMD_RSVD) begin
                  state_in = S_IDLE;
               end else if (closed_ff) begin
                  emit     = 1'b1;
                  emit_tid = (req_cmd == CMD_WAIT) ? req_thread_id : 8'd0;
                  emit_st  = ST_REFUSED;
               end else begin
                  case (req_cmd)
                     CMD_WAIT:   state_in = S_WCMP;
                     CMD_SIGNAL: state_in = S_SHEAD;
                     default: begin
                        closed_in = 1'b1;
                        state_in  = S_SHEAD;
                     end
                  endcase
               end
            end
         end
         S_WCMP: begin
            if (alu_res[32]) begin
               avail_in = alu_res[31:0];
               emit     = 1'b1;
               emit_tid = tid_ff;
               emit_st  = ST_GRANTED;
            end else if (q_full) begin
               emit     = 1'b1;
               emit_tid = tid_ff;
               emit_st  = ST_FULL;
            end else begin
               state_in = S_WNEED;
            end
         end
         S_WNEED: begin
            qctl.push = 1'b1;
            avail_in  = 32'd0;
            emit      = 1'b1;
            emit_tid  = tid_ff;
            emit_st   = ST_QUEUED;
         end
         S_SHEAD: begin
            if (!q_empty) begin
               state_in = S_SCMP;
            end else if (close_ff) begin
               emit = 1'b1;
            end else begin
               state_in = S_SADD;
            end
         end
         S_SCMP: begin
            if (close_ff) begin
               qctl.pop  = 1'b1;
               emit      = 1'b1;
               emit_tid  = q_rd_id;
               emit_st   = ST_CLOSE_REL;
               emit_last = 1'b0;
               emit_ret  = S_SHEAD;
            end else if (alu_res[32]) begin
               n_in      = alu_res[15:0];
               qctl.pop  = 1'b1;
               emit      = 1'b1;
               emit_tid  = q_rd_id;
               emit_st   = ST_RELEASED;
               emit_last = 1'b0;
               emit_ret  = S_SHEAD;
            end else begin
               state_in = S_SREM;
            end
         end
         S_SREM: begin
            qctl.upd = 1'b1;
            emit     = 1'b1;
         end
         S_SADD: begin
            avail_in = alu_res[32] ? 32'hFFFF_FFFF : alu_res[31:0];
            emit     = 1'b1;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         state_in = S_OUT;
         ret_in   = emit_ret;
      end
   end

   // result word register
   assign rsp_tid_in  = emit ? emit_tid  : rsp_tid_ff;
   assign rsp_st_in   = emit ? emit_st   : rsp_st_ff;
   assign rsp_last_in = emit ? emit_last : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         closed_ff <= 1'b0;
         close_ff  <= 1'b0;
         init_ff   <= 16'd0;
         avail_ff  <= 32'd0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         closed_ff <= closed_in;
         close_ff  <= close_in;
         init_ff   <= init_in;
         avail_ff  <= avail_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff      <= tid_in;
      n_ff        <= n_in;
      rsp_tid_ff  <= rsp_tid_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_thread_id_out = rsp_tid_ff;
   assign rsp_status        = rsp_st_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result word is pending");
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> !req_ready)
      else $error("idle before the last result word");
   a_closed_no_push: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> !qctl.push)
      else $error("waiter queued after close");
   a_init_track: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (avail_ff == {16'b0, init_ff}) && !closed_ff)
      else $error("restart did not load the initial count");
`endif

endmodule
